// File: sv/nnr_pkg.sv
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared types and codes of the nearest-neighbour resize block.
// ----------------------------------------------------------------------------
package nnr_pkg;

	localparam int PIX_W     = 32;
	localparam int RC_W      = 8;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(3);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EMIT = 1'b1;

	typedef struct packed {
		logic             func;
		logic [PIX_W-1:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic [RC_W-1:0]  out_row;
		logic [RC_W-1:0]  out_col;
		logic             plane_done;
		logic             not_loaded;
	} rsp_t;

endpackage

// File: sv/nnr_ram.sv
// ----------------------------------------------------------------------------
// nnr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/nnr_div.sv
// ----------------------------------------------------------------------------
// nnr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnr_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign done   = busy_q && (cnt_q == '0);
	assign quo    = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// quotient bits shift into the numerator register as it drains
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

endmodule

// File: sv/nearest_neighbor_resize.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_resize
// Nearest-neighbour plane resize: loads fill the plane store in raster order,
// emits walk the output plane and copy the mapped source pixel.
// ----------------------------------------------------------------------------
// Load request: one load per cycle while no emit is in progress.
// Emit request: req_stall holds until the emit is done, so a new one waits; it
//   runs S_MUL, S_STR/S_WR (row), S_STC/S_WC (column): two restoring divides on
//   the shared divider, NUM_W = clog2(MAX_DIM)+clog2(MAX_DIM+1) bits wide,
//   then S_ADDR, S_READ, S_FIN. An emit on an unloaded plane goes to S_FIN.
// Reset: sizes 1, load count and emit position zero; store contents undefined.
module nearest_neighbor_resize #(
	parameter int MAX_DIM    = 256,
	parameter int PIXEL_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  nnr_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output nnr_pkg::rsp_t                    rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nnr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nnr_pkg::CFG_W-1:0]        cfg_data
);

	localparam int POS_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int NUM_W  = POS_W + DIM_W;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PS_W   = 2 * DIM_W;
	localparam int PIX_W  = nnr_pkg::PIX_W;
	localparam int RC_W   = nnr_pkg::RC_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_STR  = 4'd2;
	localparam logic [3:0] S_WR   = 4'd3;
	localparam logic [3:0] S_STC  = 4'd4;
	localparam logic [3:0] S_WC   = 4'd5;
	localparam logic [3:0] S_ADDR = 4'd6;
	localparam logic [3:0] S_READ = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [nnr_pkg::CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	logic [nnr_pkg::CFG_W-1:0] in_height_q, in_width_q, out_height_q, out_width_q;
	logic [DIM_W-1:0]          ih, iw, oh, ow;
	logic [PS_W-1:0]           plane_size;
	logic                      loaded;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  load_cnt_q;
	logic [POS_W-1:0]  row_q, col_q;
	logic              wrap;
	logic              accept;
	logic              nl_q;
	logic [NUM_W-1:0]  prod_r_q, prod_c_q;
	logic [POS_W-1:0]  src_row_q, src_col_q;
	logic [ADDR_W-1:0] addr_q;
	logic              last;
	logic              fin_go;

	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DIM_W-1:0]  div_den;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;

	logic              ram_we;
	logic              ram_re;
	logic [PIXEL_BITS-1:0] ram_rdata;

	logic              rsp_valid_q;
	nnr_pkg::rsp_t     rsp_q;

	assign ih = eff_dim(in_height_q);
	assign iw = eff_dim(in_width_q);
	assign oh = eff_dim(out_height_q);
	assign ow = eff_dim(out_width_q);

	assign plane_size = PS_W'(ih) * PS_W'(iw);
	assign loaded     = PS_W'(load_cnt_q) >= plane_size;

	// ---- configuration ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q  <= nnr_pkg::CFG_W'(1);
			in_width_q   <= nnr_pkg::CFG_W'(1);
			out_height_q <= nnr_pkg::CFG_W'(1);
			out_width_q  <= nnr_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nnr_pkg::REG_IN_HEIGHT:  in_height_q  <= cfg_data;
				nnr_pkg::REG_IN_WIDTH:   in_width_q   <= cfg_data;
				nnr_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data;
				nnr_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- request side ----
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign ram_we    = accept && (req.func == nnr_pkg::FUNC_LOAD) && !loaded;
	assign ram_re    = (state_q == S_READ);

	// restart the walk when a size change left the position outside the plane
	assign wrap = (DIM_W'(row_q) >= oh) || (DIM_W'(col_q) >= ow);

	assign last   = (DIM_W'(row_q) == oh - DIM_W'(1)) && (DIM_W'(col_q) == ow - DIM_W'(1));
	assign fin_go = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	assign div_start = (state_q == S_STR) || (state_q == S_STC);
	assign div_num   = (state_q == S_STC) ? prod_c_q : prod_r_q;
	assign div_den   = (state_q == S_STC) ? ow : oh;

	nnr_div #(
		.NUM_W (NUM_W),
		.DEN_W (DIM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	nnr_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_cnt_q[ADDR_W-1:0]),
		.wdata (PIXEL_BITS'(req.pixel_in)),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			nl_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req.func == nnr_pkg::FUNC_LOAD)) begin
						if (!loaded) begin
							load_cnt_q <= load_cnt_q + CNT_W'(1);
						end
					end else if (accept) begin
						if (wrap) begin
							row_q <= '0;
							col_q <= '0;
						end
						nl_q    <= !loaded;
						state_q <= loaded ? S_MUL : S_FIN;
					end
				end
				S_MUL:  state_q <= S_STR;
				S_STR:  state_q <= S_WR;
				S_WR:   if (div_done) state_q <= S_STC;
				S_STC:  state_q <= S_WC;
				S_WC:   if (div_done) state_q <= S_ADDR;
				S_ADDR: state_q <= S_READ;
				S_READ: state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (!nl_q) begin
							priority if (last) begin
								row_q      <= '0;
								col_q      <= '0;
								load_cnt_q <= '0;
							end else if (DIM_W'(col_q) + DIM_W'(1) >= ow) begin
								col_q <= '0;
								row_q <= row_q + POS_W'(1);
							end else begin
								col_q <= col_q + POS_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_r_q <= NUM_W'(row_q) * NUM_W'(ih);
			prod_c_q <= NUM_W'(col_q) * NUM_W'(iw);
		end
		if ((state_q == S_WR) && div_done) begin
			src_row_q <= POS_W'(div_quo);
		end
		if ((state_q == S_WC) && div_done) begin
			src_col_q <= POS_W'(div_quo);
		end
		if (state_q == S_ADDR) begin
			addr_q <= ADDR_W'(ADDR_W'(src_row_q) * ADDR_W'(iw)) + ADDR_W'(src_col_q);
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			rsp_q.out_row    <= RC_W'(row_q);
			rsp_q.out_col    <= RC_W'(col_q);
			rsp_q.not_loaded <= nl_q;
			rsp_q.plane_done <= !nl_q && last;
			rsp_q.pixel_out  <= nl_q ? '0 : PIX_W'(ram_rdata);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
